// File: rtl/rgb_led_strip_frame_builder_macros.svh
// assertion macros for the led strip frame builder
`ifndef RGB_LED_STRIP_FRAME_BUILDER_MACROS_SVH
`define RGB_LED_STRIP_FRAME_BUILDER_MACROS_SVH

// condition must never hold outside reset
`define RLFB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

// same-cycle implication
`define RLFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication
`define RLFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// File: rtl/rlfb_pkg.sv
// shared types, codes and helpers of the led strip frame builder
package rlfb_pkg;

  localparam int MAX_LEDS_DEF = 32;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam logic [1:0] OP_SET_ALL    = 2'd0;
  localparam logic [1:0] OP_SET_BRIGHT = 2'd1;
  localparam logic [1:0] OP_REFRESH    = 2'd2;

  localparam logic [5:0] LED_COUNT_RST = 6'd32;
  localparam logic [2:0] HDR_BITS      = 3'b111;
  localparam logic [7:0] END_BYTE      = 8'hFF;
  localparam logic [6:0] END_ROUND     = 7'd15;
  localparam int         END_SHIFT     = 4;
  localparam logic [2:0] VB_FULL       = 3'd4;
  localparam int         ENTRY_W       = 29;

  typedef enum logic [1:0] {
    CMD_SET_ALL,
    CMD_SET_BRIGHT,
    CMD_REFRESH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [4:0] first;
    logic [4:0] stop;
    logic [4:0] bright;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // closing bytes of 0xff, earliest in the top byte, unused bytes zero
  function automatic logic [31:0] end_word(input logic [2:0] nbytes);
    logic [31:0] w;
    w = '0;
    for (int b = 0; b < 4; b++) begin
      if (3'(b) < nbytes) begin
        w[31 - 8*b -: 8] = END_BYTE;
      end
    end
    return w;
  endfunction

endpackage

// File: rtl/rgb_led_strip_frame_builder.sv
// top level of the led strip frame builder
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_stall   | operation, index range, brightness, colour
//  out_    | output    | out_valid/out_stall | frame word, valid byte count, last flag
//  cfg_    | input     | cfg_wr_en           | led_count
//
// a set-colour range writes each entry once, a set-brightness range reads and then writes
// each entry (read-modify-write on the single store port); the command is popped in idle.
// a refresh streams min(led_count, MAX_LEDS) + 2 words at one word per cycle while
// out_stall is low (only the start word for a zero count), paced by the store read
// port and the output register.
// synchronous reset empties the queue and clears the per-entry valid bits.
// out_stall holds the sequencer; a front register and a two-entry queue keep taking
// input transactions meanwhile.
module rgb_led_strip_frame_builder #(
  parameter int MAX_LEDS = rlfb_pkg::MAX_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_first_index,
  input  logic [4:0]  in_last_index,
  input  logic [4:0]  in_brightness,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_frame_word,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last_word
);
  import rlfb_pkg::*;

  localparam int CW = $clog2(MAX_LEDS + 1);

  logic [5:0]    led_count_r;
  logic [CW-1:0] cnt;
  logic          push, pop;
  cmd_t          push_cmd, pop_cmd;
  fifo_stat_t    fifo_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= LED_COUNT_RST;
    end else if (cfg_wr_en) begin
      led_count_r <= cfg_wr_data;
    end
  end

  // counts above the store size act as the store size
  assign cnt = (led_count_r > 6'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(led_count_r);

  rlfb_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cnt            (cnt),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_brightness  (in_brightness),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .fifo_stat      (fifo_stat),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  rlfb_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (fifo_stat)
  );

  rlfb_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cnt             (cnt),
    .fifo_cmd        (pop_cmd),
    .fifo_empty      (fifo_stat.empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_word  (out_frame_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last_word   (out_last_word)
  );

endmodule

// File: rtl/rlfb_ram.sv
// generic single-port ram with registered read
module rlfb_ram #(
  parameter int WIDTH = rlfb_pkg::ENTRY_W,
  parameter int DEPTH = rlfb_pkg::MAX_LEDS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/rlfb_front.sv
// front end: takes input transactions, classifies and clips them into commands
module rlfb_front #(
  parameter int MAX_LEDS = rlfb_pkg::MAX_LEDS_DEF,
  localparam int CW = $clog2(MAX_LEDS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CW-1:0]       cnt,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic [4:0]          in_first_index,
  input  logic [4:0]          in_last_index,
  input  logic [4:0]          in_brightness,
  input  logic [7:0]          in_red,
  input  logic [7:0]          in_green,
  input  logic [7:0]          in_blue,
  input  rlfb_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output rlfb_pkg::cmd_t      push_cmd
);
  import rlfb_pkg::*;

  localparam int IW = (CW > 5) ? CW : 5;

  cmd_t        cmd_r, cmd_nxt;
  logic        cmd_vld_r, cmd_vld_nxt;
  logic        accept;
  logic        keep;
  logic [IW-1:0] cnt_ext;
  logic        range_ok;

  assign in_stall = cmd_vld_r && fifo_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = cmd_vld_r && !fifo_stat.full;
  assign push_cmd = cmd_r;

  assign cnt_ext  = IW'(cnt);
  // entries at or above the count are skipped, an empty range does nothing
  assign range_ok = (in_first_index <= in_last_index) && (IW'(in_first_index) < cnt_ext);

  always_comb begin
    cmd_nxt.first  = in_first_index;
    cmd_nxt.stop   = (IW'(in_last_index) < cnt_ext) ? in_last_index
                                                    : 5'(cnt_ext - IW'(1));
    cmd_nxt.bright = in_brightness;
    cmd_nxt.blue   = in_blue;
    cmd_nxt.green  = in_green;
    cmd_nxt.red    = in_red;
    cmd_nxt.kind   = CMD_REFRESH;
    keep           = 1'b0;
    unique case (in_operation)
      OP_SET_ALL: begin
        cmd_nxt.kind = CMD_SET_ALL;
        keep         = range_ok;
      end
      OP_SET_BRIGHT: begin
        cmd_nxt.kind = CMD_SET_BRIGHT;
        keep         = range_ok;
      end
      OP_REFRESH: begin
        cmd_nxt.kind = CMD_REFRESH;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_vld_nxt = cmd_vld_r;
    if (accept) begin
      cmd_vld_nxt = keep;
    end else if (push) begin
      cmd_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: rtl/rlfb_cmd_fifo.sv
// short command queue between front end and sequencer
module rlfb_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rlfb_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output rlfb_pkg::cmd_t       pop_cmd,
  output rlfb_pkg::fifo_stat_t stat
);
  import rlfb_pkg::*;

  localparam int DEPTH = CMD_FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [PW:0]   fill_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == (PW+1)'(DEPTH));
  assign pop_cmd    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      if (push && !pop) begin
        fill_r <= fill_r + (PW+1)'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/rlfb_back.sv
// sequencer: carries out range writes and streams the refresh frame
module rlfb_back #(
  parameter int MAX_LEDS = rlfb_pkg::MAX_LEDS_DEF,
  localparam int CW = $clog2(MAX_LEDS + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [CW-1:0]  cnt,
  input  rlfb_pkg::cmd_t fifo_cmd,
  input  logic           fifo_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    out_frame_word,
  output logic [2:0]     out_valid_bytes,
  output logic           out_last_word
);
  import rlfb_pkg::*;

`include "rgb_led_strip_frame_builder_macros.svh"

  localparam int IW = (CW > 5) ? CW : 5;
  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_RMW_RD,
    S_RMW_WR,
    S_START,
    S_LED,
    S_END
  } state_t;

  state_t        state_r, state_nxt;
  cmd_t          cur_r, cur_nxt;
  logic [IW-1:0] idx_r, idx_nxt, idx_inc, cnt_ext;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_word_r, out_word_nxt;
  logic [2:0]    out_vb_r, out_vb_nxt;
  logic          out_last_r, out_last_nxt;

  logic               ram_wr_en, ram_rd_en;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata, entry;
  logic [MAX_LEDS-1:0] valid_r;
  logic               rd_ok_r;
  logic               out_free;
  logic [6:0]         eb_sum;
  logic [2:0]         end_bytes;

  rlfb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .rd_en   (ram_rd_en),
    .addr    (ram_addr),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_wr_en) begin
      valid_r[ram_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd_en) begin
      rd_ok_r <= valid_r[ram_addr];
    end
  end

  assign entry     = rd_ok_r ? ram_rdata : '0;
  assign cnt_ext   = IW'(cnt);
  assign idx_inc   = idx_r + IW'(1);
  assign out_free  = !out_valid_r || !out_stall;
  assign eb_sum    = 7'(cnt) + END_ROUND;
  assign end_bytes = 3'(eb_sum >> END_SHIFT);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_vb_nxt    = out_vb_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_addr      = idx_r[AW-1:0];
    ram_wdata     = {cur_r.bright, cur_r.blue, cur_r.green, cur_r.red};
    unique case (state_r)
      S_IDLE: begin
        if (!fifo_empty) begin
          pop     = 1'b1;
          cur_nxt = fifo_cmd;
          idx_nxt = IW'(fifo_cmd.first);
          unique case (fifo_cmd.kind)
            CMD_SET_ALL:    state_nxt = S_WRITE;
            CMD_SET_BRIGHT: state_nxt = S_RMW_RD;
            CMD_REFRESH:    state_nxt = S_START;
            default:        state_nxt = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        ram_wr_en = 1'b1;
        if (idx_r == IW'(cur_r.stop)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_RMW_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_RMW_WR;
      end
      S_RMW_WR: begin
        ram_wr_en = 1'b1;
        ram_wdata = {cur_r.bright, entry[23:0]};
        if (idx_r == IW'(cur_r.stop)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_RMW_RD;
        end
      end
      S_START: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '0;
          out_vb_nxt    = VB_FULL;
          out_last_nxt  = (cnt_ext == '0);
          idx_nxt       = '0;
          if (cnt_ext == '0) begin
            state_nxt = S_IDLE;
          end else begin
            // fetch the first entry while the start word goes out
            ram_rd_en = 1'b1;
            ram_addr  = '0;
            state_nxt = S_LED;
          end
        end
      end
      S_LED: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = {HDR_BITS, entry};
          out_vb_nxt    = VB_FULL;
          out_last_nxt  = 1'b0;
          if (idx_r == cnt_ext - IW'(1)) begin
            state_nxt = S_END;
          end else begin
            idx_nxt   = idx_inc;
            ram_rd_en = 1'b1;
            ram_addr  = idx_inc[AW-1:0];
          end
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = end_word(end_bytes);
          out_vb_nxt    = end_bytes;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
    out_vb_r   <= out_vb_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_frame_word  = out_word_r;
  assign out_valid_bytes = out_vb_r;
  assign out_last_word   = out_last_r;

  `RLFB_ASSERT_NEVER(a_no_rd_wr_same_cycle, clk, rst_n, ram_wr_en && ram_rd_en)
  `RLFB_ASSERT_IMPL(a_led_idx_in_range, clk, rst_n, state_r == S_LED, idx_r < cnt_ext)
  `RLFB_ASSERT_NEXT(a_last_word_ends_frame, clk, rst_n, out_valid_nxt && out_last_nxt && (!out_valid_r || !out_stall), state_r == S_IDLE)
  `RLFB_ASSERT_IMPL(a_pop_only_when_idle, clk, rst_n, pop, state_r == S_IDLE && !fifo_empty)

endmodule

// File: test/tb_rgb_led_strip_frame_builder.sv
// self-checking testbench for the led strip frame builder: directed table then random phases
module tb_rgb_led_strip_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import rlfb_pkg::*;

  localparam logic [1:0] OP_UNUSED         = 2'd3;
  localparam int         LEDS_PER_END_BYTE = 16;
  localparam int         SETTLE_CYCLES     = 300;
  localparam int         HOLD_OFF_CYCLES   = 400;
  localparam int         RANDOM_ITEMS      = 220;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] first;
    logic [4:0] last;
    logic [4:0] bright;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } strip_cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } frame_beat_t;

  typedef struct packed {
    logic [4:0] bright;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_entry_t;

  typedef struct {
    bit                do_cfg;
    logic [5:0]        cfg_val;
    strip_cmd_t        cmd;
    int                typed_n;
    frame_beat_t [2:0] typed;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  localparam frame_beat_t NO_BEAT = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [4:0]  in_first_index = '0;
  logic [4:0]  in_last_index = '0;
  logic [4:0]  in_brightness = '0;
  logic [7:0]  in_red = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_blue = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_frame_word;
  logic [2:0]  out_valid_bytes;
  logic        out_last_word;

  // predictor state
  led_entry_t  led_shadow [rlfb_pkg::MAX_LEDS_DEF];
  logic [5:0]  strip_len = LED_COUNT_RST;
  frame_beat_t frame_beats_due [$];

  dir_row_t    dir_rows [$];
  int          err_count = 0;
  int          beats_checked = 0;
  int          in_held_cycles = 0;
  int          rand_items = 0;
  int          refresh_count = 0;
  int          ignored_count = 0;
  int          cfg_writes = 0;
  int          burst_left = 0;
  bit          burst_mode = 1'b0;
  int          hold_cycles_req = 0;

  always #4 clk = ~clk;

  rgb_led_strip_frame_builder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_first_index  (in_first_index),
    .in_last_index   (in_last_index),
    .in_brightness   (in_brightness),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_word  (out_frame_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last_word   (out_last_word)
  );

  function automatic frame_beat_t beat(input logic [31:0] word, input logic [2:0] nbytes,
                                       input logic last);
    frame_beat_t b;
    b.word = word;
    b.nbytes = nbytes;
    b.last = last;
    return b;
  endfunction

  function automatic int active_leds();
    return (int'(strip_len) > rlfb_pkg::MAX_LEDS_DEF) ? rlfb_pkg::MAX_LEDS_DEF : int'(strip_len);
  endfunction

  // updates the led shadow, or queues the frame that a refresh should stream
  function automatic void predict_command(input strip_cmd_t c);
    int          n;
    int          nb;
    logic [31:0] w;
    led_entry_t  e;
    n = active_leds();
    case (c.op)
      OP_SET_ALL, OP_SET_BRIGHT: begin
        for (int i = int'(c.first); i <= int'(c.last) && i < n; i++) begin
          if (c.op == OP_SET_ALL) begin
            led_shadow[i] = '{c.bright, c.blue, c.green, c.red};
          end else begin
            led_shadow[i].bright = c.bright;
          end
        end
      end
      OP_REFRESH: begin
        frame_beats_due.push_back(beat('0, VB_FULL, n == 0));
        for (int i = 0; i < n; i++) begin
          e = led_shadow[i];
          frame_beats_due.push_back(beat({HDR_BITS, e.bright, e.blue, e.green, e.red},
                                         VB_FULL, 1'b0));
        end
        nb = (n + LEDS_PER_END_BYTE - 1) / LEDS_PER_END_BYTE;
        if (nb > 0) begin
          w = '0;
          for (int b = 0; b < nb; b++) begin
            w[31 - 8*b -: 8] = END_BYTE;
          end
          frame_beats_due.push_back(beat(w, 3'(nb), 1'b1));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t mk_row(input bit do_cfg, input logic [5:0] cfg_val,
                                      input logic [1:0] op, input logic [4:0] first,
                                      input logic [4:0] last, input logic [4:0] bright,
                                      input logic [7:0] red, input logic [7:0] green,
                                      input logic [7:0] blue, input int typed_n,
                                      input frame_beat_t t0, input frame_beat_t t1,
                                      input frame_beat_t t2);
    dir_row_t r;
    r.do_cfg = do_cfg;
    r.cfg_val = cfg_val;
    r.cmd = '{op, first, last, bright, red, green, blue};
    r.typed_n = typed_n;
    r.typed[0] = t0;
    r.typed[1] = t1;
    r.typed[2] = t2;
    return r;
  endfunction

  function automatic strip_cmd_t rand_command();
    strip_cmd_t c;
    int         pick;
    logic [4:0] a;
    logic [4:0] b;
    pick = $urandom_range(0, 19);
    if (pick < 8) c.op = OP_SET_ALL;
    else if (pick < 13) c.op = OP_SET_BRIGHT;
    else if (pick < 18) c.op = OP_REFRESH;
    else c.op = OP_UNUSED;
    a = 5'($urandom_range(0, 31));
    b = 5'($urandom_range(0, 31));
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      c.first = (a < b) ? a : b;
      c.last = (a < b) ? b : a;
    end else if (pick == 7) begin
      c.first = '0;
      c.last = '1;
    end else begin
      // may well be an empty range
      c.first = a;
      c.last = b;
    end
    c.bright = 5'($urandom_range(0, 31));
    c.red = 8'($urandom_range(0, 255));
    c.green = 8'($urandom_range(0, 255));
    c.blue = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // offers one transaction in the current burst; typed frames replace the prediction
  task automatic offer_command(input strip_cmd_t c, input int typed_n,
                               input frame_beat_t [2:0] typed);
    if (!burst_mode && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_operation <= c.op;
    in_first_index <= c.first;
    in_last_index <= c.last;
    in_brightness <= c.bright;
    in_red <= c.red;
    in_green <= c.green;
    in_blue <= c.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c.op == OP_REFRESH) refresh_count++;
    if (c.op == OP_UNUSED) ignored_count++;
    if (typed_n > 0) begin
      for (int j = 0; j < typed_n; j++) frame_beats_due.push_back(typed[j]);
    end else begin
      predict_command(c);
    end
  endtask

  // led_count may only change once the block has gone quiet
  task automatic write_led_count(input logic [5:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    strip_len = value;
    cfg_writes++;
  endtask

  // receiver: stall pattern of its own, plus an occasional long hold-off
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    rx_tick++;
    if (hold_cycles_req != 0) begin
      rx_hold_left = hold_cycles_req;
      hold_cycles_req = 0;
      out_stall <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 120);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_OPEN:     out_stall <= 1'b0;
        RX_RANDOM:   out_stall <= ($urandom_range(0, 99) < 30);
        RX_PERIODIC: out_stall <= (rx_tick % 3 == 0);
        default:     out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    frame_beat_t exp_beat;
    if (rst_n && in_valid && in_stall) in_held_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_beats_due.size() == 0) begin
        $display("%0t: unexpected frame word %h bytes %0d last %0b", $realtime,
                 out_frame_word, out_valid_bytes, out_last_word);
        err_count++;
      end else begin
        exp_beat = frame_beats_due.pop_front();
        beats_checked++;
        if (out_frame_word !== exp_beat.word) begin
          $display("%0t: frame_word expected %h actual %h", $realtime, exp_beat.word,
                   out_frame_word);
          err_count++;
        end
        if (out_valid_bytes !== exp_beat.nbytes) begin
          $display("%0t: valid_bytes expected %0d actual %0d", $realtime, exp_beat.nbytes,
                   out_valid_bytes);
          err_count++;
        end
        if (out_last_word !== exp_beat.last) begin
          $display("%0t: last_word expected %0b actual %0b", $realtime, exp_beat.last,
                   out_last_word);
          err_count++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d frame words outstanding", frame_beats_due.size());
    $display("FAIL rgb_led_strip_frame_builder");
    $finish;
  end

  initial begin
    strip_cmd_t c;
    int         phase;
    int         phase_items;
    int         pick;
    logic [5:0] new_len;

    foreach (led_shadow[i]) led_shadow[i] = '0;

    // zero count: start word only
    dir_rows.push_back(mk_row(1, 6'd0, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              1, beat('0, VB_FULL, 1'b1), NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_SET_ALL, 5'd0, 5'd31, 5'd31, 8'hFF, 8'hFF, 8'hFF,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    // one led, still cleared from reset
    dir_rows.push_back(mk_row(1, 6'd1, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              3, beat('0, VB_FULL, 1'b0), beat(32'hE000_0000, VB_FULL, 1'b0),
                              beat(32'hFF00_0000, 3'd1, 1'b1)));
    dir_rows.push_back(mk_row(0, 6'd0, OP_SET_ALL, 5'd0, 5'd0, 5'd31, 8'hFF, 8'hFF, 8'hFF,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              3, beat('0, VB_FULL, 1'b0), beat(32'hFFFF_FFFF, VB_FULL, 1'b0),
                              beat(32'hFF00_0000, 3'd1, 1'b1)));
    // brightness only, colour fields must be ignored
    dir_rows.push_back(mk_row(0, 6'd0, OP_SET_BRIGHT, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              3, beat('0, VB_FULL, 1'b0), beat(32'hE0FF_FFFF, VB_FULL, 1'b0),
                              beat(32'hFF00_0000, 3'd1, 1'b1)));
    dir_rows.push_back(mk_row(0, 6'd0, OP_UNUSED, 5'd0, 5'd31, 5'd31, 8'h00, 8'h00, 8'h00,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_REFRESH, 5'd31, 5'd31, 5'd31, 8'hFF, 8'hFF, 8'hFF,
                              3, beat('0, VB_FULL, 1'b0), beat(32'hE0FF_FFFF, VB_FULL, 1'b0),
                              beat(32'hFF00_0000, 3'd1, 1'b1)));
    // count above the store, empty range, full range
    dir_rows.push_back(mk_row(1, 6'd63, OP_SET_ALL, 5'd5, 5'd2, 5'd10, 8'hA5, 8'h5A, 8'h3C,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_SET_ALL, 5'd0, 5'd31, 5'd21, 8'h12, 8'h34, 8'h56,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_SET_BRIGHT, 5'd10, 5'd20, 5'd0, 8'hFF, 8'h00, 8'hFF,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_SET_ALL, 5'd31, 5'd31, 5'd31, 8'h00, 8'h00, 8'h00,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    // two closing bytes; range running past the count
    dir_rows.push_back(mk_row(1, 6'd17, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_SET_ALL, 5'd16, 5'd31, 5'd7, 8'hAA, 8'h55, 8'h0F,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    // entries kept while beyond the count come back
    dir_rows.push_back(mk_row(1, 6'd32, OP_SET_BRIGHT, 5'd20, 5'd31, 5'd31, 8'h00, 8'h00,
                              8'h00, 0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(0, 6'd0, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));
    dir_rows.push_back(mk_row(1, 6'd16, OP_REFRESH, 5'd0, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00,
                              0, NO_BEAT, NO_BEAT, NO_BEAT));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].do_cfg) write_led_count(dir_rows[k].cfg_val);
      offer_command(dir_rows[k].cmd, dir_rows[k].typed_n, dir_rows[k].typed);
    end

    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) new_len = 6'd0;
      else if (pick == 1) new_len = 6'($urandom_range(33, 63));
      else if (pick == 2) new_len = 6'd32;
      else if (pick == 3) new_len = 6'd1;
      else new_len = 6'($urandom_range(1, 32));
      write_led_count(new_len);

      if (phase == 2) begin
        // receiver holds off while refreshes keep coming back to back
        hold_cycles_req = HOLD_OFF_CYCLES;
        burst_mode = 1'b1;
        repeat (10) begin
          c = rand_command();
          c.op = OP_REFRESH;
          offer_command(c, 0, '0);
          rand_items++;
        end
        burst_mode = 1'b0;
      end

      phase_items = $urandom_range(15, 30);
      repeat (phase_items) begin
        c = rand_command();
        offer_command(c, 0, '0);
        rand_items++;
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frame_beats_due.size() != 0) begin
      $display("%0t: %0d frame words never arrived", $realtime, frame_beats_due.size());
      err_count++;
    end

    $display("covered %0d directed rows and %0d random transactions over %0d led_count writes",
             dir_rows.size(), rand_items, cfg_writes);
    $display("%0d refreshes, %0d unused ops, %0d frame words checked, input held off %0d cycles",
             refresh_count, ignored_count, beats_checked, in_held_cycles);
    if (err_count == 0) begin
      $display("PASS rgb_led_strip_frame_builder");
    end else begin
      $display("FAIL rgb_led_strip_frame_builder");
    end
    $finish;
  end

endmodule

// File: rgb_led_strip_frame_builder.f
+incdir+rtl
rtl/rlfb_pkg.sv
rtl/rlfb_ram.sv
rtl/rlfb_front.sv
rtl/rlfb_cmd_fifo.sv
rtl/rlfb_back.sv
rtl/rgb_led_strip_frame_builder.sv
test/tb_rgb_led_strip_frame_builder.sv
